### rtl/nearest_neighbor_image_rotator_core_defines.svh
// assertion macros for the image rotator
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATOR_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NNIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nnir assertion failed");

// next-cycle implication, disabled during reset
`define NNIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nnir assertion failed");

`endif

### rtl/nnir_pkg.sv
// types and constants of the nearest-neighbor image rotator
`default_nettype none

package nnir_pkg;

   typedef logic [7:0]         pix_type;
   typedef logic [7:0]         coord_type;
   typedef logic [8:0]         dim_type;
   typedef logic signed [15:0] coeff_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [15:0]        csr_data_type;

   localparam int FRAC_BITS = 14;

   localparam csr_index_type REG_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type REG_FRAME_HEIGHT = 2'd1;
   localparam csr_index_type REG_COS_COEFF    = 2'd2;
   localparam csr_index_type REG_SIN_COEFF    = 2'd3;

   localparam dim_type   RST_FRAME_WIDTH  = 9'd256;
   localparam dim_type   RST_FRAME_HEIGHT = 9'd256;
   localparam coeff_type RST_COS_COEFF    = 16'sd16384;
   localparam coeff_type RST_SIN_COEFF    = 16'sd0;

endpackage

`default_nettype wire

### rtl/nearest_neighbor_image_rotator_core.sv
// nearest-neighbor image rotator: frame store and inverse-mapping pipeline
// throughput: one item per cycle while rsp_stall is low, loads and queries mixed,
// set by the single port of the frame store that takes one read or one write per cycle
// stages: offset, products, sum and bounds, address, memory read
// reset stalls the input, clears pipeline valids and sets the registers to
// their defaults; the frame store is not cleared and reads garbage until written
`default_nettype none

module nearest_neighbor_image_rotator_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_func,
   input  wire nnir_pkg::coord_type    req_row,
   input  wire nnir_pkg::coord_type    req_col,
   input  wire nnir_pkg::pix_type      req_pixel_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output nnir_pkg::pix_type           rsp_pixel_out,
   output logic                        rsp_in_bounds,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire nnir_pkg::csr_index_type csr_index,
   input  wire nnir_pkg::csr_data_type  csr_data
);

   import nnir_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic signed [26:0] ROUND_ADJ = 27'sd16383;

   // configuration registers
   dim_type   frame_width_ff, frame_height_ff;
   coeff_type cos_ff, sin_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         cos_ff          <= RST_COS_COEFF;
         sin_ff          <= RST_SIN_COEFF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[8:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[8:0];
            REG_COS_COEFF:    cos_ff          <= csr_data;
            REG_SIN_COEFF:    sin_ff          <= csr_data;
            default: ;
         endcase
      end
   end

   // active frame size and center
   dim_type  act_w, act_h;
   logic [7:0] ctr_r, ctr_c;

   always_comb begin
      act_w = frame_width_ff;
      if (frame_width_ff == '0) begin
         act_w = 9'd1;
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         act_w = 9'(MAX_WIDTH);
      end
      act_h = frame_height_ff;
      if (frame_height_ff == '0) begin
         act_h = 9'd1;
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         act_h = 9'(MAX_HEIGHT);
      end
      ctr_r = act_h[8:1];
      ctr_c = act_w[8:1];
   end

   // pipeline flow control
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   logic s1_load_ff, s2_load_ff, s3_load_ff, s4_load_ff;
   logic rdy_out, rdy4, rdy3, rdy2, rdy1;

   assign rdy_out   = !out_v_ff || !rsp_stall;
   assign rdy4      = !s4_v_ff || s4_load_ff || rdy_out;
   assign rdy3      = !s3_v_ff || rdy4;
   assign rdy2      = !s2_v_ff || rdy3;
   assign rdy1      = !s1_v_ff || rdy2;
   assign req_stall = reset || !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_v_ff <= req_valid;
         end
         if (rdy2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (rdy3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (rdy4) begin
            s4_v_ff <= s3_v_ff;
         end
         if (rdy_out) begin
            out_v_ff <= s4_v_ff && !s4_load_ff;
         end
      end
   end

   // stage 1: offsets from the center
   coord_type s1_row_ff, s1_col_ff;
   pix_type   s1_pix_ff;
   logic signed [9:0] s1_dr_ff, s1_dc_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_load_ff <= !req_func;
         s1_row_ff  <= req_row;
         s1_col_ff  <= req_col;
         s1_pix_ff  <= req_pixel_in;
         s1_dr_ff   <= $signed({2'b00, req_row}) - $signed({2'b00, ctr_r});
         s1_dc_ff   <= $signed({2'b00, req_col}) - $signed({2'b00, ctr_c});
      end
   end

   // stage 2: rotation products
   coord_type s2_row_ff, s2_col_ff;
   pix_type   s2_pix_ff;
   logic signed [25:0] s2_cr_ff, s2_sc_ff, s2_sr_ff, s2_cc_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_load_ff <= s1_load_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_pix_ff  <= s1_pix_ff;
         s2_cr_ff   <= cos_ff * s1_dr_ff;
         s2_sc_ff   <= sin_ff * s1_dc_ff;
         s2_sr_ff   <= sin_ff * s1_dr_ff;
         s2_cc_ff   <= cos_ff * s1_dc_ff;
      end
   end

   // stage 3: sums, truncation toward zero, center, bounds
   logic signed [26:0] sum_r, sum_c, adj_r, adj_c;
   logic signed [13:0] src_r, src_c;
   logic [8:0] s3_r_in, s3_c_in;
   logic       s3_inb_in;

   always_comb begin
      sum_r = {s2_cr_ff[25], s2_cr_ff} - {s2_sc_ff[25], s2_sc_ff};
      sum_c = {s2_sr_ff[25], s2_sr_ff} + {s2_cc_ff[25], s2_cc_ff};
      adj_r = sum_r + (sum_r[26] ? ROUND_ADJ : 27'sd0);
      adj_c = sum_c + (sum_c[26] ? ROUND_ADJ : 27'sd0);
      src_r = {adj_r[26], adj_r[26:FRAC_BITS]} + $signed({6'b0, ctr_r});
      src_c = {adj_c[26], adj_c[26:FRAC_BITS]} + $signed({6'b0, ctr_c});
      if (s2_load_ff) begin
         s3_r_in   = {1'b0, s2_row_ff};
         s3_c_in   = {1'b0, s2_col_ff};
         s3_inb_in = (32'(s2_row_ff) < MAX_HEIGHT) && (32'(s2_col_ff) < MAX_WIDTH);
      end else begin
         s3_r_in   = src_r[8:0];
         s3_c_in   = src_c[8:0];
         s3_inb_in = !src_r[13] && (src_r < $signed({5'b0, act_h}))
                  && !src_c[13] && (src_c < $signed({5'b0, act_w}));
      end
   end

   logic [8:0] s3_r_ff, s3_c_ff;
   logic       s3_inb_ff;
   pix_type    s3_pix_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_load_ff <= s2_load_ff;
         s3_r_ff    <= s3_r_in;
         s3_c_ff    <= s3_c_in;
         s3_inb_ff  <= s3_inb_in;
         s3_pix_ff  <= s2_pix_ff;
      end
   end

   // stage 4: store address
   logic [ADDR_W-1:0] s4_addr_ff;
   logic              s4_inb_ff;
   pix_type           s4_pix_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_load_ff <= s3_load_ff;
         s4_addr_ff <= ADDR_W'(32'(s3_r_ff) * MAX_WIDTH + 32'(s3_c_ff));
         s4_inb_ff  <= s3_inb_ff;
         s4_pix_ff  <= s3_pix_ff;
      end
   end

   // frame store, one access per cycle
   pix_type mem [DEPTH];
   pix_type rd_ff;
   logic    out_inb_ff;
   logic    mem_we, mem_re;

   assign mem_we = s4_v_ff && s4_load_ff && s4_inb_ff;
   assign mem_re = s4_v_ff && !s4_load_ff && s4_inb_ff && rdy_out;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s4_addr_ff] <= s4_pix_ff;
      end
      if (mem_re) begin
         rd_ff <= mem[s4_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out && s4_v_ff && !s4_load_ff) begin
         out_inb_ff <= s4_inb_ff;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_in_bounds = out_inb_ff;
   assign rsp_pixel_out = out_inb_ff ? rd_ff : '0;

endmodule

`default_nettype wire

### rtl/nnir_checker.sv
// port-level checks of the image rotator and their binding
`default_nettype none

`include "nearest_neighbor_image_rotator_core_defines.svh"

module nnir_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire nnir_pkg::pix_type       rsp_pixel_out,
   input wire logic                    rsp_in_bounds
);

   // a stalled item keeps its payload
   `NNIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_in_bounds))

   // a point outside the frame reads as black
   `NNIR_ASSERT_NOW(a_oob_zero, clock, reset, rsp_valid && !rsp_in_bounds,
      rsp_pixel_out == '0)

   // no item leaves right after reset
   `NNIR_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

   // no item can appear too soon after reset to have passed through the pipeline registers
   `NNIR_ASSERT_NOW(a_min_latency, clock, reset,
      $rose(rsp_valid) && $past(reset, 4), 1'b0)

endmodule

bind nearest_neighbor_image_rotator_core nnir_checker u_nnir_checker (.*);

`default_nettype wire

### verif/nearest_neighbor_image_rotator_core_test.sv
// self-checking testbench for the nearest-neighbor image rotator core
`timescale 1ns / 1ps

import nnir_pkg::*;

localparam int   STORE_SIDE = 256;
localparam logic FUNC_LOAD  = 1'b0;
localparam logic FUNC_QUERY = 1'b1;

typedef struct packed {
   pix_type pixel;
   logic    in_bounds;
} rotated_pixel_type;

class frame_rotation_predictor;
   pix_type           src_pixels[int];
   rotated_pixel_type awaited_pixels[$];
   dim_type           width_reg;
   dim_type           height_reg;
   coeff_type         cos_reg;
   coeff_type         sin_reg;
   int                errors;
   int                loads;
   int                queries;
   int                hits;

   function void reset_regs();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      cos_reg    = RST_COS_COEFF;
      sin_reg    = RST_SIN_COEFF;
   endfunction

   function void write_reg(csr_index_type idx, csr_data_type value);
      case (idx)
         REG_FRAME_WIDTH: begin
            width_reg = value[8:0];
         end
         REG_FRAME_HEIGHT: begin
            height_reg = value[8:0];
         end
         REG_COS_COEFF: begin
            cos_reg = coeff_type'(value);
         end
         default: begin
            sin_reg = coeff_type'(value);
         end
      endcase
   endfunction

   function longint active_size(dim_type d);
      if (d == 9'd0) begin
         return 1;
      end
      if (int'(d) > STORE_SIDE) begin
         return STORE_SIDE;
      end
      return longint'(d);
   endfunction

   // inverse mapping of a destination point onto the source frame
   function void map_back(coord_type row, coord_type col, output longint src_row,
                          output longint src_col, output bit in_frame);
      longint w;
      longint h;
      longint dr;
      longint dc;
      longint one;
      w   = active_size(width_reg);
      h   = active_size(height_reg);
      one = longint'(1) << FRAC_BITS;
      dr  = longint'(row) - h / 2;
      dc  = longint'(col) - w / 2;
      src_row = (longint'(cos_reg) * dr - longint'(sin_reg) * dc) / one + h / 2;
      src_col = (longint'(sin_reg) * dr + longint'(cos_reg) * dc) / one + w / 2;
      in_frame = src_row >= 0 && src_row < h && src_col >= 0 && src_col < w;
   endfunction

   function void take_item(logic func, coord_type row, coord_type col, pix_type pixel_in);
      longint            src_row;
      longint            src_col;
      bit                in_frame;
      rotated_pixel_type res;
      int                addr;
      if (func == FUNC_LOAD) begin
         src_pixels[int'(row) * STORE_SIDE + int'(col)] = pixel_in;
         loads++;
      end else begin
         map_back(row, col, src_row, src_col, in_frame);
         res.in_bounds = in_frame;
         res.pixel     = 8'd0;
         if (in_frame) begin
            addr = int'(src_row) * STORE_SIDE + int'(src_col);
            if (src_pixels.exists(addr)) begin
               res.pixel = src_pixels[addr];
            end
            hits++;
         end
         awaited_pixels.push_back(res);
         queries++;
      end
   endfunction

   function void compare_pixel(pix_type pixel, logic in_bounds);
      rotated_pixel_type want;
      if (awaited_pixels.size() == 0) begin
         $display("%0t: result with nothing pending: pixel_out %0d in_bounds %0b",
                  $time, pixel, in_bounds);
         errors++;
         return;
      end
      want = awaited_pixels.pop_front();
      if (in_bounds !== want.in_bounds) begin
         $display("%0t: in_bounds expected %0b actual %0b", $time, want.in_bounds, in_bounds);
         errors++;
      end
      if (pixel !== want.pixel) begin
         $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel, pixel);
         errors++;
      end
   endfunction
endclass

module nearest_neighbor_image_rotator_core_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 10;

   logic          clock         = 1'b0;
   logic          reset         = 1'b1;
   logic          req_valid     = 1'b0;
   logic          req_stall;
   logic          req_func      = FUNC_LOAD;
   coord_type     req_row       = '0;
   coord_type     req_col       = '0;
   pix_type       req_pixel_in  = '0;
   logic          rsp_valid;
   logic          rsp_stall     = 1'b0;
   pix_type       rsp_pixel_out;
   logic          rsp_in_bounds;
   logic          csr_valid     = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index     = REG_FRAME_WIDTH;
   csr_data_type  csr_data      = '0;

   frame_rotation_predictor rotator;

   bit send_calm     = 1'b1;
   bit rsp_calm      = 1'b1;
   int results_taken = 0;
   int results_seen  = 0;
   int rsp_hold      = 0;
   int idle_cycles   = 0;
   int settings_used = 0;

   nearest_neighbor_image_rotator_core i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic send_item(logic func, coord_type row, coord_type col, pix_type pixel_in);
      int gap;
      gap = draw_gap(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_row      <= row;
      req_col      <= col;
      req_pixel_in <= pixel_in;
      do @(posedge clock); while (!(req_valid && !req_stall));
      rotator.take_item(func, row, col, pixel_in);
   endtask

   // a query that lands on an unwritten source pixel gets that pixel loaded first
   task automatic send_query(coord_type row, coord_type col);
      longint src_row;
      longint src_col;
      bit     in_frame;
      rotator.map_back(row, col, src_row, src_col, in_frame);
      if (in_frame && !rotator.src_pixels.exists(int'(src_row) * STORE_SIDE + int'(src_col)))
      begin
         send_item(FUNC_LOAD, coord_type'(src_row), coord_type'(src_col), 8'($urandom));
      end
      send_item(FUNC_QUERY, row, col, 8'($urandom));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rotator.awaited_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      rotator.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(csr_data_type w_data, csr_data_type h_data,
                                 coeff_type cos_val, coeff_type sin_val);
      wait_idle();
      write_reg(REG_FRAME_WIDTH, w_data);
      write_reg(REG_FRAME_HEIGHT, h_data);
      write_reg(REG_COS_COEFF, csr_data_type'(cos_val));
      write_reg(REG_SIN_COEFF, csr_data_type'(sin_val));
      settings_used++;
   endtask

   task automatic random_items(int count);
      int        w;
      int        h;
      int        pick;
      bit        wide;
      coord_type row;
      coord_type col;
      w = int'(rotator.active_size(rotator.width_reg));
      h = int'(rotator.active_size(rotator.height_reg));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         wide = (pick < 5) || (pick >= 90);
         if (wide) begin
            row = 8'($urandom);
            col = 8'($urandom);
         end else begin
            row = 8'($urandom_range(0, (h + 7 > 255) ? 255 : h + 7));
            col = 8'($urandom_range(0, (w + 7 > 255) ? 255 : w + 7));
         end
         if (pick < 30) begin
            send_item(FUNC_LOAD, row, col, 8'($urandom));
         end else begin
            send_query(row, col);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rotator.compare_pixel(rsp_pixel_out, rsp_in_bounds);
         results_taken++;
      end
   end

   // receiver holds off for a fresh random count after every result, unless rsp_calm is set
   always @(negedge clock) begin
      if (results_taken != results_seen) begin
         results_seen = results_taken;
         rsp_hold     = draw_gap(rsp_calm);
      end
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[nearest_neighbor_image_rotator_core] ERROR");
         $finish;
      end
   end

   initial begin
      int        w_raw;
      int        h_raw;
      coeff_type cos_val;
      coeff_type sin_val;
      rotator = new();
      rotator.reset_regs();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity mapping at the reset defaults, frame corners
      send_calm = 1'b1;
      rsp_calm  = 1'b0;
      send_item(FUNC_LOAD, 8'd0, 8'd0, 8'h00);
      send_item(FUNC_LOAD, 8'd255, 8'd255, 8'hFF);
      send_item(FUNC_LOAD, 8'd0, 8'd255, 8'hA5);
      send_item(FUNC_LOAD, 8'd255, 8'd0, 8'h5A);
      send_query(8'd0, 8'd0);
      send_query(8'd255, 8'd255);
      send_query(8'd0, 8'd255);
      send_query(8'd255, 8'd0);
      send_query(8'd128, 8'd128);

      // half turn: the top-left corner maps just past the frame
      send_calm = 1'b0;
      apply_settings(16'd256, 16'd256, -16'sd16384, 16'sd0);
      send_query(8'd0, 8'd0);
      send_query(8'd255, 8'd255);
      send_query(8'd128, 8'd0);

      // quarter turn
      rsp_calm = 1'b1;
      apply_settings(16'd256, 16'd256, 16'sd0, 16'sd16384);
      send_query(8'd0, 8'd0);
      send_query(8'd10, 8'd20);
      send_query(8'd255, 8'd255);

      // zero size acts as one pixel, coefficients at their extremes
      apply_settings(16'hFE00, 16'h0000, -16'sd32768, 16'sd32767);
      send_query(8'd0, 8'd0);
      send_query(8'd1, 8'd0);
      send_item(FUNC_LOAD, 8'd200, 8'd17, 8'h3C);
      send_query(8'd255, 8'd255);

      // oversize frame clamps to the store, truncation toward zero of negatives
      send_calm = 1'b1;
      rsp_calm  = 1'b0;
      apply_settings(16'h01FF, 16'h012C, 16'sd32767, -16'sd32768);
      send_query(8'd128, 8'd128);
      send_query(8'd130, 8'd126);

      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin
               w_raw = $urandom_range(1, 16);
               h_raw = $urandom_range(1, 16);
            end
            1: begin
               w_raw = $urandom_range(1, 256);
               h_raw = $urandom_range(1, 256);
            end
            2: begin
               w_raw = 256;
               h_raw = 256;
            end
            default: begin
               w_raw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
               h_raw = $urandom_range(0, 511);
            end
         endcase
         if (p % 3 == 2) begin
            cos_val = coeff_type'($urandom);
            sin_val = coeff_type'($urandom);
         end else begin
            cos_val = coeff_type'($urandom_range(0, 32768) - 16384);
            sin_val = coeff_type'($urandom_range(0, 32768) - 16384);
         end
         send_calm = ($urandom_range(0, 3) == 0);
         rsp_calm  = ($urandom_range(0, 3) == 0);
         apply_settings({7'($urandom), 9'(w_raw)}, {7'($urandom), 9'(h_raw)},
                        cos_val, sin_val);
         random_items(80);
      end

      wait_idle();
      $display("covered %0d loads and %0d queries (%0d in bounds) over %0d register settings",
               rotator.loads, rotator.queries, rotator.hits, settings_used + 1);
      if (rotator.errors == 0 && rotator.awaited_pixels.size() == 0) begin
         $display("[nearest_neighbor_image_rotator_core] OK");
      end else begin
         $display("[nearest_neighbor_image_rotator_core] ERROR");
      end
      $finish;
   end

endmodule
